// ===== rtl/core/ptd_pkg.sv =====
package ptd_pkg;

  // Field widths of the request and result items
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned RELOAD_W = 8;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CFG_W    = 16;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_OVERFLOW   = 2'd0,
    REQ_CREATE     = 2'd1,
    REQ_SET_ACTIVE = 2'd2
  } req_type_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_OVERFLOWS_PER_TICK = 1'b0,
    CFG_TIMER_RELOAD_VALUE = 1'b1
  } cfg_reg_t;

  // Decoded command for the slot table
  typedef struct packed {
    logic                tick;
    logic                create;
    logic                set_active;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] delay;
    logic                active;
  } slot_cmd_t;

endpackage

// ===== rtl/core/ptd_in_if.sv =====
interface ptd_in_if;
  logic                            valid;
  logic                            ready;
  logic [ptd_pkg::REQ_W-1:0]       req_type;
  logic [ptd_pkg::SLOT_W-1:0]      slot;
  logic [ptd_pkg::PERIOD_W-1:0]    task_period;
  logic [ptd_pkg::PERIOD_W-1:0]    first_delay;
  logic                            task_active;

  modport source (output valid, req_type, slot, task_period, first_delay, task_active,
                  input ready);
  modport sink   (input valid, req_type, slot, task_period, first_delay, task_active,
                  output ready);
endinterface

// ===== rtl/core/ptd_out_if.sv =====
interface ptd_out_if;
  logic                            valid;
  logic                            ready;
  logic [ptd_pkg::MASK_W-1:0]      fire_mask;
  logic                            timer_reload;
  logic [ptd_pkg::RELOAD_W-1:0]    reload_value;
  logic                            slot_error;

  modport source (output valid, fire_mask, timer_reload, reload_value, slot_error,
                  input ready);
  modport sink   (input valid, fire_mask, timer_reload, reload_value, slot_error,
                  output ready);
endinterface

// ===== rtl/core/ptd_tick_counter.sv =====
module ptd_tick_counter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         overflow,
  input  logic [ptd_pkg::COUNT_W-1:0]  overflows_per_tick,
  output logic                         tick
);

  logic [ptd_pkg::COUNT_W-1:0] count_r;
  logic [ptd_pkg::COUNT_W-1:0] count_nxt;
  logic [ptd_pkg::COUNT_W-1:0] count_inc;

  // Count wraps mod 2^16; a tick when the incremented count matches
  assign count_inc = count_r + ptd_pkg::COUNT_W'(1);
  assign tick      = overflow && (count_inc == overflows_per_tick);

  always_comb begin
    count_nxt = count_r;
    if (tick) begin
      count_nxt = '0;
    end else if (overflow) begin
      count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/ptd_slot_bank.sv =====
module ptd_slot_bank #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_vld,
  input  ptd_pkg::slot_cmd_t          cmd,
  output logic [ptd_pkg::MASK_W-1:0]  fire_mask
);

  logic [NUM_SLOTS-1:0]        present_r;
  logic [NUM_SLOTS-1:0]        active_r;
  logic [ptd_pkg::PERIOD_W-1:0] period_r    [NUM_SLOTS];
  logic [ptd_pkg::PERIOD_W-1:0] countdown_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]        fire;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    logic hit;
    logic run;

    // One cell per slot: match, run on tick, update
    assign hit     = (cmd.slot == ptd_pkg::SLOT_W'(i));
    assign run     = cmd_vld && cmd.tick && present_r[i] && active_r[i];
    assign fire[i] = run && (countdown_r[i] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        present_r[i] <= 1'b0;
        active_r[i]  <= 1'b0;
      end else if (cmd_vld && hit && (cmd.create || cmd.set_active)) begin
        present_r[i] <= present_r[i] || cmd.create;
        active_r[i]  <= cmd.active;
      end
    end

    // Period and countdown: loaded by create, countdown reloaded on fire and decremented on run, no reset
    always_ff @(posedge clk) begin
      if (cmd_vld && hit && cmd.create) begin
        period_r[i]    <= cmd.period;
        countdown_r[i] <= cmd.delay;
      end else if (fire[i]) begin
        countdown_r[i] <= period_r[i];
      end else if (run) begin
        countdown_r[i] <= countdown_r[i] - ptd_pkg::PERIOD_W'(1);
      end
    end
  end

  // Only the low slots show in the mask
  for (genvar b = 0; b < ptd_pkg::MASK_W; b++) begin : g_mask
    if (b < NUM_SLOTS) begin : g_used
      assign fire_mask[b] = fire[b];
    end else begin : g_unused
      assign fire_mask[b] = 1'b0;
    end
  end

endmodule

// ===== rtl/core/periodic_task_dispatcher_unit.sv =====
// Periodic task dispatcher: time-triggered cooperative scheduler.
// in_chan carries one request per item: a timer overflow, a task creation
// in a slot, or a change of a slot's active flag. out_chan returns exactly
// one result per request: the mask of slots dispatched, the timer reload
// pulse with its value, and a flag for a slot index out of range.
// Registers are to be written through cfg_we/cfg_idx/cfg_wdata only while
// idle; the block does not enforce this. Index 0 overflows per tick, index 1 timer reload value.
// A request passes through one input register, then the decode and the
// parallel update of all slot cells, which feeds the result register.
// Throughput is one request per cycle while out_chan does not stall, set
// by the per-slot countdown cells all updating in the same cycle.
// When out_chan stalls, the result register holds and one more request is
// still taken into the input register; in_chan.ready then drops.
// Reset (synchronous, rst_n low) clears the overflow count, all present and
// active flags and both pipeline valids; configuration returns to one
// overflow per tick and a reload value of zero. No clearing pass is needed.
module periodic_task_dispatcher_unit #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ptd_in_if.sink                        in_chan,
  ptd_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [ptd_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [ptd_pkg::COUNT_W-1:0]  ovf_per_tick_r;
  logic [ptd_pkg::RELOAD_W-1:0] reload_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_per_tick_r <= ptd_pkg::COUNT_W'(1);
      reload_val_r   <= '0;
    end else if (cfg_we) begin
      unique case (ptd_pkg::cfg_reg_t'(cfg_idx))
        ptd_pkg::CFG_OVERFLOWS_PER_TICK: ovf_per_tick_r <= cfg_wdata[ptd_pkg::COUNT_W-1:0];
        ptd_pkg::CFG_TIMER_RELOAD_VALUE: reload_val_r   <= cfg_wdata[ptd_pkg::RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_vld_r;
  logic in_vld_nxt;
  logic out_vld_r;
  logic out_vld_nxt;
  logic advance;
  logic proc;
  logic accept;

  assign advance       = !out_vld_r || out_chan.ready;
  assign proc          = in_vld_r && advance;
  assign in_chan.ready = !in_vld_r || advance;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (proc) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register
  logic [ptd_pkg::REQ_W-1:0]    req_r;
  logic [ptd_pkg::SLOT_W-1:0]   slot_r;
  logic [ptd_pkg::PERIOD_W-1:0] period_r;
  logic [ptd_pkg::PERIOD_W-1:0] delay_r;
  logic                         active_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_chan.req_type;
      slot_r   <= in_chan.slot;
      period_r <= in_chan.task_period;
      delay_r  <= in_chan.first_delay;
      active_r <= in_chan.task_active;
    end
  end

  // Request decode
  logic is_ovf;
  logic is_slot_req;
  logic is_create;
  logic slot_ok;

  always_comb begin
    is_ovf      = 1'b0;
    is_slot_req = 1'b0;
    is_create   = 1'b0;
    unique case (ptd_pkg::req_type_t'(req_r))
      ptd_pkg::REQ_OVERFLOW:   is_ovf = 1'b1;
      ptd_pkg::REQ_CREATE: begin
        is_slot_req = 1'b1;
        is_create   = 1'b1;
      end
      ptd_pkg::REQ_SET_ACTIVE: is_slot_req = 1'b1;
      default: ;
    endcase
  end

  assign slot_ok = ({1'b0, slot_r} < (ptd_pkg::SLOT_W + 1)'(NUM_SLOTS));

  // Overflow counter
  logic tick;

  ptd_tick_counter u_tick (
    .clk                (clk),
    .rst_n              (rst_n),
    .overflow           (proc && is_ovf),
    .overflows_per_tick (ovf_per_tick_r),
    .tick               (tick)
  );

  // Slot table
  ptd_pkg::slot_cmd_t          cmd;
  logic [ptd_pkg::MASK_W-1:0]  fire_mask;

  always_comb begin
    cmd.tick       = tick;
    cmd.create     = is_create && slot_ok;
    cmd.set_active = is_slot_req && !is_create && slot_ok;
    cmd.slot       = slot_r;
    cmd.period     = period_r;
    cmd.delay      = delay_r;
    cmd.active     = active_r;
  end

  ptd_slot_bank #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_vld   (proc),
    .cmd       (cmd),
    .fire_mask (fire_mask)
  );

  // Result register
  logic [ptd_pkg::MASK_W-1:0]   mask_r;
  logic                         reload_r;
  logic [ptd_pkg::RELOAD_W-1:0] rvalue_r;
  logic                         err_r;

  always_ff @(posedge clk) begin
    if (proc) begin
      mask_r   <= fire_mask;
      reload_r <= tick;
      rvalue_r <= tick ? reload_val_r : '0;
      err_r    <= is_slot_req && !slot_ok;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.fire_mask    = mask_r;
  assign out_chan.timer_reload = reload_r;
  assign out_chan.reload_value = rvalue_r;
  assign out_chan.slot_error   = err_r;

endmodule

// ===== dv/ptd_dispatch_checker.sv =====
// Watches both channels and the register port of the dispatcher, keeps its own
// copy of the scheduler state and compares every result against the prediction.
module ptd_dispatch_checker #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ptd_in_if                         in_mon,
  ptd_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [ptd_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked,
  output int                        ticks,
  output int                        fires
);

  typedef struct packed {
    logic [ptd_pkg::REQ_W-1:0]    kind;
    logic [ptd_pkg::SLOT_W-1:0]   slot;
    logic [ptd_pkg::PERIOD_W-1:0] period;
    logic [ptd_pkg::PERIOD_W-1:0] delay;
    logic                         active;
  } sched_req_t;

  typedef struct packed {
    logic [ptd_pkg::MASK_W-1:0]   fire_mask;
    logic                         timer_reload;
    logic [ptd_pkg::RELOAD_W-1:0] reload_value;
    logic                         slot_error;
  } dispatch_result_t;

  // Scheduler copy: configuration, overflow count and slot table
  logic [ptd_pkg::COUNT_W-1:0]  ticks_cfg;
  logic [ptd_pkg::RELOAD_W-1:0] reload_cfg;
  logic [ptd_pkg::COUNT_W-1:0]  ovf_count;
  logic                         slot_present [NUM_SLOTS];
  logic                         slot_active  [NUM_SLOTS];
  logic [ptd_pkg::PERIOD_W-1:0] slot_period  [NUM_SLOTS];
  logic [ptd_pkg::PERIOD_W-1:0] slot_count   [NUM_SLOTS];

  dispatch_result_t    pending_results [$];

  initial begin
    fail_count = 0;
    checked    = 0;
    ticks      = 0;
    fires      = 0;
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    // keep the log short when the block is badly broken
    if (fail_count <= 40) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Next dispatch result for one request; updates the scheduler copy
  function automatic dispatch_result_t predict_dispatch(input sched_req_t rq);
    dispatch_result_t res;
    res = '0;
    case (rq.kind) inside
      ptd_pkg::REQ_OVERFLOW: begin
        ovf_count = ovf_count + 1'b1;
        if (ovf_count == ticks_cfg) begin
          ovf_count          = '0;
          res.timer_reload   = 1'b1;
          res.reload_value   = reload_cfg;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_present[i] && slot_active[i]) begin
              if (slot_count[i] == '0) begin
                slot_count[i] = slot_period[i];
                if (i < ptd_pkg::MASK_W) res.fire_mask[i] = 1'b1;
              end else begin
                slot_count[i] = slot_count[i] - 1'b1;
              end
            end
          end
        end
      end
      ptd_pkg::REQ_CREATE, ptd_pkg::REQ_SET_ACTIVE: begin
        if (rq.slot >= NUM_SLOTS) begin
          res.slot_error = 1'b1;
        end else if (rq.kind == ptd_pkg::REQ_CREATE) begin
          slot_present[rq.slot] = 1'b1;
          slot_active[rq.slot]  = rq.active;
          slot_period[rq.slot]  = rq.period;
          slot_count[rq.slot]   = rq.delay;
        end else begin
          // stored even on an empty slot
          slot_active[rq.slot] = rq.active;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track configuration, check results, queue predictions
  always @(posedge clk) begin : monitor
    dispatch_result_t want;
    sched_req_t       rq;
    if (!rst_n) begin
      ticks_cfg  = ptd_pkg::COUNT_W'(1);
      reload_cfg = '0;
      ovf_count  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_present[i] = 1'b0;
        slot_active[i]  = 1'b0;
        slot_period[i]  = '0;
        slot_count[i]   = '0;
      end
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ptd_pkg::CFG_OVERFLOWS_PER_TICK: ticks_cfg  = cfg_wdata[ptd_pkg::COUNT_W-1:0];
          ptd_pkg::CFG_TIMER_RELOAD_VALUE: reload_cfg = cfg_wdata[ptd_pkg::RELOAD_W-1:0];
          default: ;
        endcase
      end
      // result side first: it always belongs to an older request
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: mask %h reload %b",
                                  out_mon.fire_mask, out_mon.timer_reload));
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (want.timer_reload) ticks++;
          fires += $countones(want.fire_mask);
          if (out_mon.fire_mask !== want.fire_mask)
            flag_mismatch($sformatf("fire_mask got %h want %h (result %0d)",
                                    out_mon.fire_mask, want.fire_mask, checked));
          if (out_mon.timer_reload !== want.timer_reload)
            flag_mismatch($sformatf("timer_reload got %b want %b (result %0d)",
                                    out_mon.timer_reload, want.timer_reload, checked));
          if (out_mon.reload_value !== want.reload_value)
            flag_mismatch($sformatf("reload_value got %h want %h (result %0d)",
                                    out_mon.reload_value, want.reload_value, checked));
          if (out_mon.slot_error !== want.slot_error)
            flag_mismatch($sformatf("slot_error got %b want %b (result %0d)",
                                    out_mon.slot_error, want.slot_error, checked));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        rq.kind   = in_mon.req_type;
        rq.slot   = in_mon.slot;
        rq.period = in_mon.task_period;
        rq.delay  = in_mon.first_delay;
        rq.active = in_mon.task_active;
        pending_results.push_back(predict_dispatch(rq));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int unsigned NUM_SLOTS = 8;
  // request code that the block leaves unused
  localparam logic [ptd_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [ptd_pkg::CFG_W-1:0] cfg_wdata;
  bit                        quiet = 1'b0;
  int                        sent = 0;
  int                        send_odds = 0;

  int fail_count, outstanding, checked, ticks, fires;

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  periodic_task_dispatcher_unit #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ptd_dispatch_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .ticks       (ticks),
    .fires       (fires)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_req(input logic [ptd_pkg::REQ_W-1:0] kind,
                          input logic [ptd_pkg::SLOT_W-1:0] slot,
                          input logic [ptd_pkg::PERIOD_W-1:0] period,
                          input logic [ptd_pkg::PERIOD_W-1:0] delay, input logic active);
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.slot        <= slot;
    in_ch.task_period <= period;
    in_ch.first_delay <= delay;
    in_ch.task_active <= active;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Random sender gap with in_ch.valid low
  task automatic sender_gap();
    if (!quiet && send_odds != 0 && $urandom_range(0, send_odds * 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Mostly in-range slots and short periods so that slots fire often
  task automatic send_random_req();
    int                           pick;
    logic [ptd_pkg::REQ_W-1:0]    kind;
    logic [ptd_pkg::SLOT_W-1:0]   slot;
    logic [ptd_pkg::PERIOD_W-1:0] period;
    logic [ptd_pkg::PERIOD_W-1:0] delay;
    logic                         active;
    pick = $urandom_range(0, 99);
    if (pick < 48)      kind = ptd_pkg::REQ_OVERFLOW;
    else if (pick < 72) kind = ptd_pkg::REQ_CREATE;
    else if (pick < 96) kind = ptd_pkg::REQ_SET_ACTIVE;
    else                kind = REQ_UNUSED;
    slot   = ($urandom_range(0, 9) == 0) ? ptd_pkg::SLOT_W'($urandom_range(8, 255))
                                         : ptd_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    period = ($urandom_range(0, 5) == 0) ? ptd_pkg::PERIOD_W'($urandom)
                                         : ptd_pkg::PERIOD_W'($urandom_range(0, 4));
    delay  = ($urandom_range(0, 5) == 0) ? ptd_pkg::PERIOD_W'($urandom)
                                         : ptd_pkg::PERIOD_W'($urandom_range(0, 4));
    active = ($urandom_range(0, 4) != 0);
    send_req(kind, slot, period, delay, active);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Both registers, back to back, only while idle
  task automatic program_regs(input logic [ptd_pkg::COUNT_W-1:0] per_tick,
                              input logic [ptd_pkg::RELOAD_W-1:0] reload);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= ptd_pkg::CFG_OVERFLOWS_PER_TICK;
    cfg_wdata <= ptd_pkg::CFG_W'(per_tick);
    @(posedge clk);
    cfg_idx   <= ptd_pkg::CFG_TIMER_RELOAD_VALUE;
    cfg_wdata <= ptd_pkg::CFG_W'(reload);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int gap_left;
    int taken;
    int odds;
    int cyc;
    bit held;
    gap_left = 0;
    taken    = 0;
    odds     = 0;
    cyc      = 0;
    held     = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (cyc % 64 == 0) odds = $urandom_range(0, 2);
      cyc++;
      if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && taken >= 300) begin
        held     = 1'b1;
        gap_left = 249;
        out_ch.ready <= 1'b0;
      end else if (!quiet && odds != 0 && $urandom_range(0, odds * 5) == 0) begin
        gap_left = $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [ptd_pkg::COUNT_W-1:0]  per_tick;
    logic [ptd_pkg::RELOAD_W-1:0] reload;
    int                           waited;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= ptd_pkg::REQ_OVERFLOW;
    in_ch.slot        <= '0;
    in_ch.task_period <= '0;
    in_ch.first_delay <= '0;
    in_ch.task_active <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= ptd_pkg::CFG_OVERFLOWS_PER_TICK;
    cfg_wdata         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: one overflow per tick, reload zero
    send_req(ptd_pkg::REQ_CREATE,     8'd0,   8'd0,   8'd0,   1'b1);
    send_req(ptd_pkg::REQ_CREATE,     8'd7,   8'd255, 8'd255, 1'b1);
    send_req(ptd_pkg::REQ_CREATE,     8'd8,   8'd1,   8'd1,   1'b1);  // just past the last slot
    send_req(ptd_pkg::REQ_CREATE,     8'd255, 8'd255, 8'd255, 1'b1);
    send_req(ptd_pkg::REQ_SET_ACTIVE, 8'd200, 8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_SET_ACTIVE, 8'd3,   8'd0,   8'd0,   1'b1);  // flag on an empty slot
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_CREATE,     8'd3,   8'd1,   8'd0,   1'b0);  // creation overrides flag
    send_req(ptd_pkg::REQ_CREATE,     8'd5,   8'd2,   8'd1,   1'b1);
    send_req(REQ_UNUSED,              8'd5,   8'd255, 8'd255, 1'b1);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_SET_ACTIVE, 8'd3,   8'd0,   8'd0,   1'b1);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_SET_ACTIVE, 8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_CREATE,     8'd5,   8'd3,   8'd0,   1'b1);  // re-create a live slot
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_CREATE,     8'd7,   8'd0,   8'd0,   1'b1);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd0,   8'd0,   8'd0,   1'b0);
    send_req(ptd_pkg::REQ_OVERFLOW,   8'd255, 8'd255, 8'd255, 1'b1);

    // Random part over several settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin per_tick = 16'd1; reload = 8'd255; end
        1:       begin per_tick = 16'd2; reload = ptd_pkg::RELOAD_W'($urandom); end
        2:       begin per_tick = 16'd3; reload = 8'd0; end
        default: begin
          per_tick = ptd_pkg::COUNT_W'($urandom_range(1, 4));
          reload   = ptd_pkg::RELOAD_W'($urandom);
        end
      endcase
      program_regs(per_tick, reload);
      for (int n = 0; n < 195; n++) begin
        if (n % 50 == 0) send_odds = $urandom_range(0, 2);
        sender_gap();
        send_random_req();
      end
    end

    // Last part, no idling: a lowered, a zero and the top threshold hold off the tick
    drain();
    quiet <= 1'b1;
    program_regs(16'd5, 8'h11);
    for (int s = 0; s < NUM_SLOTS; s++)
      send_req(ptd_pkg::REQ_CREATE, ptd_pkg::SLOT_W'(s), ptd_pkg::PERIOD_W'(s % 3),
               ptd_pkg::PERIOD_W'(s % 2), 1'b1);
    repeat (3) send_req(ptd_pkg::REQ_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b0);
    program_regs(16'd2, 8'h5A);
    repeat (10) send_req(ptd_pkg::REQ_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b0);
    program_regs(16'd0, 8'hA5);
    repeat (10) send_req(ptd_pkg::REQ_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b0);
    program_regs(16'd65535, 8'h3C);
    repeat (10) send_req(ptd_pkg::REQ_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b0);
    program_regs(16'd1, 8'hC3);
    repeat (8) send_req(ptd_pkg::REQ_OVERFLOW, 8'd0, 8'd0, 8'd0, 1'b0);
    in_ch.valid <= 1'b0;

    // Wait for the last results, then let the block settle before the verdict
    waited = 0;
    while (outstanding != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);

    $display("Covered %0d requests, %0d results compared, %0d ticks, %0d slot dispatches",
             sent, checked, ticks, fires);
    $display("Thresholds 1 to 5, lowered, zero and top thresholds, long result hold-off");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== periodic_task_dispatcher_unit.f =====
rtl/core/ptd_pkg.sv
rtl/core/ptd_in_if.sv
rtl/core/ptd_out_if.sv
rtl/core/ptd_tick_counter.sv
rtl/core/ptd_slot_bank.sv
rtl/core/periodic_task_dispatcher_unit.sv
dv/ptd_dispatch_checker.sv
dv/tb_top.sv
